// File: rtl/i2cb_pkg.sv
// Shared types and constants for the I2C master bit engine.
package i2cb_pkg;

   // Command codes as seen on the request mode field
   localparam logic [2:0] MODE_TICK  = 3'd0;
   localparam logic [2:0] MODE_START = 3'd1;
   localparam logic [2:0] MODE_STOP  = 3'd2;
   localparam logic [2:0] MODE_WRITE = 3'd3;
   localparam logic [2:0] MODE_READ  = 3'd4;
   localparam logic [2:0] MODE_ACK   = 3'd5;

   localparam int unsigned QDEPTH  = 2;
   localparam int unsigned QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   typedef enum logic [2:0] {
      CMD_NONE  = 3'd0,
      CMD_START = 3'd1,
      CMD_STOP  = 3'd2,
      CMD_WRITE = 3'd3,
      CMD_READ  = 3'd4,
      CMD_ACK   = 3'd5
   } cmd_type;

   // Classified tick word handed from the front end to the sequencer
   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] tx_byte;
      logic       ack_bit;
      logic       sda_in;
      logic       scl_in;
   } item_type;

   // Result word for one tick
   typedef struct packed {
      logic       scl_drive;
      logic       sda_drive;
      logic       busy_res;
      logic       done_res;
      logic       ok_flag;
      logic [7:0] read_byte;
   } rsp_type;

endpackage

// File: rtl/i2cb_front.sv
// Front end: accepts tick words, decodes the mode and queues them for the sequencer.
module i2cb_front import i2cb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [2:0] mode,
   input  logic [7:0] tx_byte,
   input  logic       ack_bit,
   input  logic       sda_in,
   input  logic       scl_in,
   output logic       item_valid,
   output item_type   item,
   input  logic       item_take
);

   item_type              slot_ff [QDEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]     count_ff, count_in;
   item_type              decoded;
   logic                  do_push, do_pop;

   // Map raw mode to a command; unused codes become plain ticks
   always_comb begin
      decoded.tx_byte = tx_byte;
      decoded.ack_bit = ack_bit;
      decoded.sda_in  = sda_in;
      decoded.scl_in  = scl_in;
      case (mode)
         MODE_START: decoded.cmd = CMD_START;
         MODE_STOP:  decoded.cmd = CMD_STOP;
         MODE_WRITE: decoded.cmd = CMD_WRITE;
         MODE_READ:  decoded.cmd = CMD_READ;
         MODE_ACK:   decoded.cmd = CMD_ACK;
         default:    decoded.cmd = CMD_NONE;
      endcase
   end

   assign full       = (count_ff == QCNT_W'(QDEPTH));
   assign item_valid = (count_ff != '0);
   assign item       = slot_ff[rd_ptr_ff];
   assign do_push    = push & ~full;
   assign do_pop     = item_take & item_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

// File: rtl/i2cb_seq.sv
// Back end: the bit sequencer, one phase per tick word.
module i2cb_seq import i2cb_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     item_valid,
   input  item_type item,
   output logic     item_take,
   input  logic     out_room,
   output logic     rsp_valid,
   output rsp_type  rsp
);

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_ONE   = 3'd1,
      PH_TWO   = 3'd2,
      PH_THREE = 3'd3,
      PH_FOUR  = 3'd4,
      PH_FIVE  = 3'd5
   } phase_type;

   phase_type  phase_ff, phase_in;
   cmd_type    cmd_ff, cmd_in;
   logic [3:0] bit_count_ff, bit_count_in;
   logic [7:0] shift_ff, shift_in;
   logic       status_ff, status_in;
   logic       scl_ff, scl_in;
   logic       sda_ff, sda_in;
   logic [7:0] rx_hold_ff, rx_hold_in;
   logic [3:0] bit_count_inc;
   logic       finish, busy, done;

   assign item_take     = item_valid & out_room;
   assign rsp_valid     = item_take;
   assign bit_count_inc = bit_count_ff + 1'b1;

   always_comb begin
      phase_in     = phase_ff;
      cmd_in       = cmd_ff;
      bit_count_in = bit_count_ff;
      shift_in     = shift_ff;
      status_in    = status_ff;
      scl_in       = scl_ff;
      sda_in       = sda_ff;
      rx_hold_in   = rx_hold_ff;
      finish       = 1'b0;
      busy         = 1'b0;
      done         = 1'b0;

      if (phase_ff == PH_IDLE) begin
         if (item.cmd != CMD_NONE) begin
            status_in = 1'b1;
            cmd_in    = item.cmd;
            phase_in  = PH_ONE;
            busy      = 1'b1;
            case (item.cmd)
               CMD_START: begin
                  sda_in = 1'b1;
                  scl_in = 1'b1;
               end
               CMD_STOP: begin
                  sda_in = 1'b0;
                  scl_in = 1'b1;
               end
               CMD_WRITE: begin
                  sda_in       = item.tx_byte[7];
                  shift_in     = {item.tx_byte[6:0], 1'b0};
                  bit_count_in = 4'd1;
               end
               CMD_READ: begin
                  sda_in       = 1'b1;
                  scl_in       = 1'b0;
                  shift_in     = '0;
                  bit_count_in = '0;
               end
               default: begin
                  scl_in = 1'b0;
                  sda_in = ~item.ack_bit;
               end
            endcase
         end
      end else begin
         case (cmd_ff)
            CMD_START: begin
               if (phase_ff == PH_ONE) begin
                  if (!item.sda_in) begin
                     status_in = 1'b0;
                     finish    = 1'b1;
                  end else begin
                     sda_in   = 1'b0;
                     phase_in = PH_TWO;
                  end
               end else begin
                  scl_in    = 1'b0;
                  status_in = 1'b1;
                  finish    = 1'b1;
               end
            end
            CMD_STOP: begin
               // hold while the slave stretches the clock
               if (phase_ff == PH_ONE) begin
                  if (item.scl_in) begin
                     sda_in   = 1'b1;
                     phase_in = PH_TWO;
                  end
               end else begin
                  finish = 1'b1;
               end
            end
            CMD_WRITE: begin
               case (phase_ff)
                  PH_ONE: begin
                     scl_in   = 1'b1;
                     phase_in = PH_TWO;
                  end
                  PH_TWO: begin
                     scl_in = 1'b0;
                     if (bit_count_ff < BITS_PER_BYTE) begin
                        sda_in       = shift_ff[7];
                        shift_in     = {shift_ff[6:0], 1'b0};
                        bit_count_in = bit_count_inc;
                        phase_in     = PH_ONE;
                     end else begin
                        sda_in   = 1'b1;
                        phase_in = PH_THREE;
                     end
                  end
                  PH_THREE: begin
                     scl_in   = 1'b1;
                     phase_in = PH_FOUR;
                  end
                  PH_FOUR: begin
                     status_in = ~item.sda_in;
                     scl_in    = 1'b0;
                     phase_in  = PH_FIVE;
                  end
                  default: finish = 1'b1;
               endcase
            end
            CMD_READ: begin
               if (phase_ff == PH_ONE) begin
                  scl_in   = 1'b1;
                  phase_in = PH_TWO;
               end else begin
                  shift_in     = {shift_ff[6:0], item.sda_in};
                  bit_count_in = bit_count_inc;
                  scl_in       = 1'b0;
                  if (bit_count_inc >= BITS_PER_BYTE) begin
                     rx_hold_in = shift_in;
                     finish     = 1'b1;
                  end else begin
                     phase_in = PH_ONE;
                  end
               end
            end
            CMD_ACK: begin
               case (phase_ff)
                  PH_ONE: begin
                     scl_in   = 1'b1;
                     phase_in = PH_TWO;
                  end
                  PH_TWO: begin
                     scl_in   = 1'b0;
                     phase_in = PH_THREE;
                  end
                  default: begin
                     sda_in = 1'b1;
                     finish = 1'b1;
                  end
               endcase
            end
            default: finish = 1'b1;
         endcase

         if (finish) begin
            phase_in = PH_IDLE;
            cmd_in   = CMD_NONE;
            done     = 1'b1;
         end else begin
            busy = 1'b1;
         end
      end

      rsp.scl_drive = scl_in;
      rsp.sda_drive = sda_in;
      rsp.busy_res  = busy;
      rsp.done_res  = done;
      rsp.ok_flag   = status_in;
      rsp.read_byte = rx_hold_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         cmd_ff       <= CMD_NONE;
         bit_count_ff <= '0;
         shift_ff     <= '0;
         status_ff    <= 1'b1;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         rx_hold_ff   <= '0;
      end else if (item_take) begin
         phase_ff     <= phase_in;
         cmd_ff       <= cmd_in;
         bit_count_ff <= bit_count_in;
         shift_ff     <= shift_in;
         status_ff    <= status_in;
         scl_ff       <= scl_in;
         sda_ff       <= sda_in;
         rx_hold_ff   <= rx_hold_in;
      end
   end

endmodule

// File: rtl/i2cb_outq.sv
// Result queue between the sequencer and the result channel.
module i2cb_outq import i2cb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_valid,
   input  rsp_type wr_data,
   output logic    wr_room,
   input  logic    pop,
   output logic    empty,
   output rsp_type head
);

   rsp_type           slot_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign wr_room = (count_ff != QCNT_W'(QDEPTH));
   assign empty   = (count_ff == '0);
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = wr_valid & wr_room;
   assign do_pop  = pop & ~empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// File: rtl/i2c_master_bit_engine.sv
// I2C master bit engine top level: front queue, bit sequencer and result queue.
//
// Use: each word pushed on the req_ channel is one bus delay tick. It carries
// the sampled SDA and SCL levels and, while the engine is idle, a command in
// req_mode (tick only, start, stop, write byte, read byte, send acknowledge).
// A word is taken at a rising edge with push high and full low.
// Every tick word yields exactly one result word on the rsp_ channel: the
// open-drain drives for SCL and SDA, busy, done, the ok flag and the last
// byte read. The oldest result sits on the rsp_ ports while empty is low and
// leaves at an edge with pop high.
// Path: a taken tick word is stored in the two-word front queue; the
// sequencer takes it from there when the result queue has room and writes its
// result into the two-word result queue at that edge. Throughput: one word per
// cycle while the result queue has room; the sequencer advances one phase per
// word, with its state update as the only loop.
// Stalls: when pop stays low the result queue fills, the sequencer holds its
// state, the front queue fills and full rises; no word is lost or repeated.
// Reset: synchronous, active high; queues empty, sequencer idle, both lines
// released, ok flag set, read byte cleared.
module i2c_master_bit_engine import i2cb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   // tick word channel
   input  logic       push,
   output logic       full,
   input  logic [2:0] req_mode,
   input  logic [7:0] req_tx_byte,
   input  logic       req_ack_bit,
   input  logic       req_sda_in,
   input  logic       req_scl_in,
   // result word channel
   output logic       empty,
   input  logic       pop,
   output logic       rsp_scl_drive,
   output logic       rsp_sda_drive,
   output logic       rsp_busy_res,
   output logic       rsp_done_res,
   output logic       rsp_ok_flag,
   output logic [7:0] rsp_read_byte
);

   item_type item;
   logic     item_valid;
   logic     item_take;
   logic     out_room;
   logic     seq_valid;
   rsp_type  seq_rsp;
   rsp_type  head;

   // Decode and buffer incoming tick words
   i2cb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .mode       (req_mode),
      .tx_byte    (req_tx_byte),
      .ack_bit    (req_ack_bit),
      .sda_in     (req_sda_in),
      .scl_in     (req_scl_in),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   // Advance the pin sequence one phase per word, only when a result slot is free
   i2cb_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .out_room   (out_room),
      .rsp_valid  (seq_valid),
      .rsp        (seq_rsp)
   );

   // Hold results until the receiver pops them
   i2cb_outq u_outq (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (seq_valid),
      .wr_data  (seq_rsp),
      .wr_room  (out_room),
      .pop      (pop),
      .empty    (empty),
      .head     (head)
   );

   assign rsp_scl_drive = head.scl_drive;
   assign rsp_sda_drive = head.sda_drive;
   assign rsp_busy_res  = head.busy_res;
   assign rsp_done_res  = head.done_res;
   assign rsp_ok_flag   = head.ok_flag;
   assign rsp_read_byte = head.read_byte;

endmodule

// File: dv/i2cb_tb_pkg.sv
// Bus pin-sequence model and result-word checker for the I2C bit engine testbench.
package i2cb_tb_pkg;
   import i2cb_pkg::*;

   localparam logic [4:0] PH_IDLE  = 5'd0;
   localparam logic [4:0] PH_ONE   = 5'd1;
   localparam logic [4:0] PH_TWO   = 5'd2;
   localparam logic [4:0] PH_THREE = 5'd3;
   localparam logic [4:0] PH_FOUR  = 5'd4;
   localparam logic [4:0] PH_FIVE  = 5'd5;

   // Mode codes with no command behind them
   localparam logic [2:0] MODE_SPARE_LO = 3'd6;
   localparam logic [2:0] MODE_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] tx_byte;
      logic       ack_bit;
      logic       sda_in;
      logic       scl_in;
   } tick_word;

   // Steps the engine one bus tick and gives the pin drives and status
   class pin_sequence_model;
      logic [4:0] phase;
      logic [2:0] command;
      logic [3:0] bit_count;
      logic [7:0] shift_reg;
      logic       status_flag;
      logic       scl_level;
      logic       sda_level;
      logic [7:0] rx_hold;

      function new();
         phase       = PH_IDLE;
         command     = MODE_TICK;
         bit_count   = '0;
         shift_reg   = '0;
         status_flag = 1'b1;
         scl_level   = 1'b1;
         sda_level   = 1'b1;
         rx_hold     = '0;
      endfunction

      function bit idle();
         return phase == PH_IDLE;
      endfunction

      function rsp_type step(tick_word w);
         rsp_type r;
         bit      busy;
         bit      done;
         busy = 1'b0;
         done = 1'b0;
         if (phase == PH_IDLE) begin
            if (w.mode >= MODE_START && w.mode <= MODE_ACK) begin
               busy        = 1'b1;
               status_flag = 1'b1;
               command     = w.mode;
               phase       = PH_ONE;
               case (w.mode)
                  MODE_START: begin
                     sda_level = 1'b1;
                     scl_level = 1'b1;
                  end
                  MODE_STOP: begin
                     sda_level = 1'b0;
                     scl_level = 1'b1;
                  end
                  MODE_WRITE: begin
                     sda_level = w.tx_byte[7];
                     shift_reg = {w.tx_byte[6:0], 1'b0};
                     bit_count = 4'd1;
                  end
                  MODE_READ: begin
                     sda_level = 1'b1;
                     scl_level = 1'b0;
                     shift_reg = '0;
                     bit_count = '0;
                  end
                  default: begin
                     scl_level = 1'b0;
                     sda_level = !w.ack_bit;
                  end
               endcase
            end
         end else begin
            case (command)
               MODE_START: begin
                  if (phase == PH_ONE) begin
                     if (!w.sda_in) begin
                        status_flag = 1'b0;
                        done        = 1'b1;
                     end else begin
                        sda_level = 1'b0;
                        phase     = PH_TWO;
                     end
                  end else begin
                     scl_level   = 1'b0;
                     status_flag = 1'b1;
                     done        = 1'b1;
                  end
               end
               MODE_STOP: begin
                  if (phase == PH_ONE) begin
                     // clock stretching: hold here until the slave lets SCL go
                     if (w.scl_in) begin
                        sda_level = 1'b1;
                        phase     = PH_TWO;
                     end
                  end else begin
                     done = 1'b1;
                  end
               end
               MODE_WRITE: begin
                  case (phase)
                     PH_ONE: begin
                        scl_level = 1'b1;
                        phase     = PH_TWO;
                     end
                     PH_TWO: begin
                        scl_level = 1'b0;
                        if (bit_count < BITS_PER_BYTE) begin
                           sda_level = shift_reg[7];
                           shift_reg = {shift_reg[6:0], 1'b0};
                           bit_count = bit_count + 4'd1;
                           phase     = PH_ONE;
                        end else begin
                           sda_level = 1'b1;
                           phase     = PH_THREE;
                        end
                     end
                     PH_THREE: begin
                        scl_level = 1'b1;
                        phase     = PH_FOUR;
                     end
                     PH_FOUR: begin
                        status_flag = !w.sda_in;
                        scl_level   = 1'b0;
                        phase       = PH_FIVE;
                     end
                     default: done = 1'b1;
                  endcase
               end
               MODE_READ: begin
                  if (phase == PH_ONE) begin
                     scl_level = 1'b1;
                     phase     = PH_TWO;
                  end else begin
                     shift_reg = {shift_reg[6:0], w.sda_in};
                     bit_count = bit_count + 4'd1;
                     scl_level = 1'b0;
                     if (bit_count >= BITS_PER_BYTE) begin
                        rx_hold = shift_reg;
                        done    = 1'b1;
                     end else begin
                        phase = PH_ONE;
                     end
                  end
               end
               MODE_ACK: begin
                  case (phase)
                     PH_ONE: begin
                        scl_level = 1'b1;
                        phase     = PH_TWO;
                     end
                     PH_TWO: begin
                        scl_level = 1'b0;
                        phase     = PH_THREE;
                     end
                     default: begin
                        sda_level = 1'b1;
                        done      = 1'b1;
                     end
                  endcase
               end
               default: done = 1'b1;
            endcase
            if (done) begin
               phase   = PH_IDLE;
               command = MODE_TICK;
            end else begin
               busy = 1'b1;
            end
         end
         r.scl_drive = scl_level;
         r.sda_drive = sda_level;
         r.busy_res  = busy;
         r.done_res  = done;
         r.ok_flag   = status_flag;
         r.read_byte = rx_hold;
         return r;
      endfunction
   endclass

   // Holds the pin states owed by the block, oldest first
   class tick_scoreboard;
      pin_sequence_model engine;
      rsp_type           owed_pins[$];
      int unsigned       mismatches;
      int unsigned       words_checked;

      function new();
         engine        = new();
         mismatches    = 0;
         words_checked = 0;
      endfunction

      function void note_word(tick_word w);
         owed_pins.push_back(engine.step(w));
      endfunction

      function int unsigned pending();
         return owed_pins.size();
      endfunction

      task report_mismatch(string what);
         $display("ERROR: result word %0d: %s", words_checked, what);
         mismatches++;
      endtask

      task check_word(rsp_type got);
         rsp_type want;
         if (owed_pins.size() == 0) begin
            report_mismatch("result word with no tick word behind it");
         end else begin
            want = owed_pins.pop_front();
            if (got.scl_drive !== want.scl_drive)
               report_mismatch($sformatf("scl_drive %b, want %b", got.scl_drive,
                                         want.scl_drive));
            if (got.sda_drive !== want.sda_drive)
               report_mismatch($sformatf("sda_drive %b, want %b", got.sda_drive,
                                         want.sda_drive));
            if (got.busy_res !== want.busy_res)
               report_mismatch($sformatf("busy_res %b, want %b", got.busy_res,
                                         want.busy_res));
            if (got.done_res !== want.done_res)
               report_mismatch($sformatf("done_res %b, want %b", got.done_res,
                                         want.done_res));
            if (got.ok_flag !== want.ok_flag)
               report_mismatch($sformatf("ok_flag %b, want %b", got.ok_flag,
                                         want.ok_flag));
            if (got.read_byte !== want.read_byte)
               report_mismatch($sformatf("read_byte %h, want %h", got.read_byte,
                                         want.read_byte));
         end
         words_checked++;
      endtask
   endclass

endpackage

// File: dv/tb_i2c_master_bit_engine.sv
// Self-checking testbench for the I2C master bit engine: directed and random bus ticks.
module tb_i2c_master_bit_engine;
   import i2cb_pkg::*;
   import i2cb_tb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned WORD_TARGET = 1700;
   localparam int unsigned IDLE_PCT    = 22;
   localparam int unsigned HOLD_CYCLES = 150;
   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned DRAIN_TICKS = 12;

   logic       clock;
   logic       reset       = 1'b1;
   logic       push        = 1'b0;
   logic       full;
   logic [2:0] req_mode    = MODE_TICK;
   logic [7:0] req_tx_byte = '0;
   logic       req_ack_bit = 1'b0;
   logic       req_sda_in  = 1'b1;
   logic       req_scl_in  = 1'b1;
   logic       empty;
   logic       pop         = 1'b0;
   logic       rsp_scl_drive;
   logic       rsp_sda_drive;
   logic       rsp_busy_res;
   logic       rsp_done_res;
   logic       rsp_ok_flag;
   logic [7:0] rsp_read_byte;

   // checker side: owes one pin state per accepted tick word
   tick_scoreboard    sb   = new();
   // stimulus side: tracks where each command is so the next one lands on idle
   pin_sequence_model plan = new();

   bit          req_idle_on = 1'b1;
   bit          rsp_idle_on = 1'b1;
   bit          hold_req    = 1'b0;
   int unsigned words_sent  = 0;
   int unsigned quiet_ticks = 0;

   i2c_master_bit_engine u_dut (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_mode      (req_mode),
      .req_tx_byte   (req_tx_byte),
      .req_ack_bit   (req_ack_bit),
      .req_sda_in    (req_sda_in),
      .req_scl_in    (req_scl_in),
      .empty         (empty),
      .pop           (pop),
      .rsp_scl_drive (rsp_scl_drive),
      .rsp_sda_drive (rsp_sda_drive),
      .rsp_busy_res  (rsp_busy_res),
      .rsp_done_res  (rsp_done_res),
      .rsp_ok_flag   (rsp_ok_flag),
      .rsp_read_byte (rsp_read_byte)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Offer one tick word from a falling edge and hold it until it is taken.
   // Enter and leave at a falling edge; push is left high for the caller.
   task automatic send_word(tick_word w);
      if (req_idle_on && $urandom_range(99) < IDLE_PCT) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push        <= 1'b1;
      req_mode    <= w.mode;
      req_tx_byte <= w.tx_byte;
      req_ack_bit <= w.ack_bit;
      req_sda_in  <= w.sda_in;
      req_scl_in  <= w.scl_in;
      do @(posedge clock); while (!(push && !full));
      words_sent++;
      @(negedge clock);
   endtask

   // Issue one command word, then feed bus ticks until the command is over.
   // Busy ticks carry stray modes so that commands while busy get exercised.
   // The first 'stretch' ticks hold SCL low (slave stretching the clock).
   task automatic run_command(logic [2:0] mode, logic [7:0] tx, logic ack,
                              int unsigned sda_one_pct, int unsigned scl_one_pct,
                              int unsigned stretch);
      tick_word    w;
      int unsigned n;
      w.mode    = mode;
      w.tx_byte = tx;
      w.ack_bit = ack;
      w.sda_in  = 1'($urandom_range(1));
      w.scl_in  = 1'($urandom_range(1));
      send_word(w);
      void'(plan.step(w));
      n = 0;
      while (!plan.idle()) begin
         w.mode    = ($urandom_range(99) < 70) ? MODE_TICK : 3'($urandom_range(7));
         w.tx_byte = 8'($urandom);
         w.ack_bit = 1'($urandom_range(1));
         w.sda_in  = $urandom_range(99) < sda_one_pct;
         w.scl_in  = (n < stretch) ? 1'b0 : ($urandom_range(99) < scl_one_pct);
         n++;
         send_word(w);
         void'(plan.step(w));
      end
   endtask

   // Drop push and wait for every owed result word to come back
   task automatic drain_results();
      push <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
   endtask

   // Receiver: pop at random, with one long hold-off on request
   initial begin
      int unsigned held;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            pop <= 1'b0;
            // count the hold-off here so the sender runs into a full queue
            for (held = 1; held < HOLD_CYCLES; held++)
               @(negedge clock);
         end else begin
            pop <= !(rsp_idle_on && $urandom_range(99) < IDLE_PCT);
         end
      end
   end

   // Note accepted tick words first, then check accepted result words
   always @(posedge clock) begin : watch_ports
      tick_word taken;
      rsp_type  seen;
      if (!reset) begin
         if (push && !full) begin
            taken.mode    = req_mode;
            taken.tx_byte = req_tx_byte;
            taken.ack_bit = req_ack_bit;
            taken.sda_in  = req_sda_in;
            taken.scl_in  = req_scl_in;
            sb.note_word(taken);
         end
         if (pop && !empty) begin
            seen.scl_drive = rsp_scl_drive;
            seen.sda_drive = rsp_sda_drive;
            seen.busy_res  = rsp_busy_res;
            seen.done_res  = rsp_done_res;
            seen.ok_flag   = rsp_ok_flag;
            seen.read_byte = rsp_read_byte;
            sb.check_word(seen);
         end
      end
   end

   // Watchdog: end the run when neither side has moved a word for too long
   always @(posedge clock) begin
      if (!reset) begin
         if ((push && !full) || (pop && !empty))
            quiet_ticks = 0;
         else
            quiet_ticks++;
         if (quiet_ticks >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      logic [2:0]  mode;
      int unsigned sda_pct;
      int unsigned scl_pct;
      int unsigned stretch;
      bit          hold_done;
      bit          pause_done;
      hold_done  = 1'b0;
      pause_done = 1'b0;

      // hold reset across rising edges, then release it at a falling edge
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: each command at its edges
      run_command(MODE_START, 8'h00, 1'b0, 100, 100, 0); // bus free
      run_command(MODE_START, 8'hFF, 1'b1, 0, 100, 0);   // SDA held low, start fails
      run_command(MODE_WRITE, 8'hFF, 1'b0, 0, 50, 0);    // slave acknowledges
      run_command(MODE_WRITE, 8'h00, 1'b1, 100, 50, 0);  // no acknowledge
      run_command(MODE_WRITE, 8'hA5, 1'b0, 50, 50, 0);
      run_command(MODE_READ, 8'h00, 1'b0, 100, 50, 0);   // all ones in
      run_command(MODE_READ, 8'hFF, 1'b1, 0, 50, 0);     // all zeros in
      run_command(MODE_ACK, 8'h00, 1'b1, 50, 50, 0);     // drive ACK
      run_command(MODE_ACK, 8'hFF, 1'b0, 50, 50, 0);     // release for NACK
      run_command(MODE_STOP, 8'h00, 1'b0, 50, 100, 5);   // clock held low first
      run_command(MODE_STOP, 8'hFF, 1'b1, 50, 100, 0);
      run_command(MODE_TICK, 8'h5A, 1'b1, 50, 50, 0);    // plain idle tick
      run_command(MODE_SPARE_LO, 8'hC3, 1'b0, 50, 50, 0); // unused modes idle
      run_command(MODE_SPARE_HI, 8'h3C, 1'b1, 50, 50, 0);

      // Random part: start with a stretch where neither side idles
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      while (words_sent < WORD_TARGET) begin
         if (words_sent >= 400) begin
            req_idle_on = 1'b1;
            rsp_idle_on = 1'b1;
         end
         if (!hold_done && words_sent >= 800) begin
            hold_done = 1'b1;
            hold_req  = 1'b1;
         end
         if (!pause_done && words_sent >= 1200) begin
            pause_done = 1'b1;
            drain_results();
         end

         stretch = 0;
         sda_pct = 50;
         scl_pct = 50;
         if ($urandom_range(99) < 12) begin
            // idle tick, sometimes on an unused mode
            mode = ($urandom_range(2) == 0) ? MODE_TICK
                 : 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
         end else begin
            mode = 3'($urandom_range(MODE_START, MODE_ACK));
            case (mode)
               MODE_START: sda_pct = 85;
               MODE_STOP: begin
                  scl_pct = 100;
                  if ($urandom_range(3) == 0)
                     stretch = $urandom_range(1, 6);
               end
               default: ;
            endcase
         end
         run_command(mode, 8'($urandom), 1'($urandom_range(1)), sda_pct, scl_pct,
                     stretch);
      end

      // Wind down: let the queues empty, then allow for the pipeline depth
      drain_results();
      repeat (DRAIN_TICKS) @(negedge clock);
      if (sb.mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
